// ===== sv/rfo_pkg.sv =====
// ----------------------------------------------------------------------------
// rfo_pkg
// Shared widths, command and status codes, and defaults for the ring FIFO.
// ----------------------------------------------------------------------------
package rfo_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 5;

   localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_READ      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_OVERWRITE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== sv/rfo_ram.sv =====
// ----------------------------------------------------------------------------
// rfo_ram
// Entry store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rfo_ram
   import rfo_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] store_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued, so a stalled item keeps its value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ring_fifo_with_overwrite_unit.sv =====
// ----------------------------------------------------------------------------
// ring_fifo_with_overwrite_unit
// Accepted items pass the result stage, then the output register. Throughput:
// one item per cycle unless rsp_stall holds the output; the entry store has one
// read and one write port, and pointers and count live in registers next to it.
// Reset clears positions and count and sets the capacity to 16; the entry
// store is not cleared, so the block accepts items right after reset.
// ----------------------------------------------------------------------------
module ring_fifo_with_overwrite_unit
   import rfo_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [VALUE_WIDTH-1:0] req_write_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_WIDTH-1:0] rsp_read_value,
   output logic [STATUS_W-1:0]    rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_capacity_in_use
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

   logic [CFG_W-1:0] cap_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                p1_valid_ff, p1_valid_in;
   logic [STATUS_W-1:0] p1_status_ff;
   logic                p1_hit_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [VALUE_WIDTH-1:0] rsp_read_value_ff;

   logic [CW-1:0]          cap_ext, cap_eff, cnt_ext, head_inc, tail_inc;
   logic [PTR_W-1:0]       head_adv, tail_adv;
   logic                   full, empty, accept, p1_adv;
   logic [STATUS_W-1:0]    status_in;
   logic                   hit_in;
   logic                   wr_en, rd_en;
   logic [PTR_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   // Capacity register: zero acts as one, anything above the depth as the depth.
   assign cap_ext = CW'(cap_ff);
   assign cap_eff = (cap_ff == '0)        ? CW'(1)   :
                    (cap_ext > DEPTH_CW)  ? DEPTH_CW : cap_ext;
   assign cnt_ext = CW'(count_ff);
   assign full    = (cnt_ext >= cap_eff);
   assign empty   = (count_ff == '0);

   assign head_inc = CW'(head_ff) + CW'(1);
   assign tail_inc = CW'(tail_ff) + CW'(1);
   assign head_adv = (head_inc >= cap_eff) ? '0 : head_inc[PTR_W-1:0];
   assign tail_adv = (tail_inc >= cap_eff) ? '0 : tail_inc[PTR_W-1:0];

   // The result stage moves on when the output register is free or being taken.
   assign p1_adv    = p1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = p1_valid_ff & ~p1_adv;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = STAT_OK;
      hit_in    = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = tail_ff;
      if (accept) begin
         unique case (req_command) inside
            CMD_READ: begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  hit_in   = 1'b1;
                  head_in  = head_adv;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            CMD_WRITE, CMD_OVERWRITE: begin
               if (!full) begin
                  wr_en    = 1'b1;
                  tail_in  = tail_adv;
                  count_in = count_ff + CNT_W'(1);
               end else if (req_command == CMD_WRITE) begin
                  status_in = STAT_FULL;
               end else begin
                  // A full ring drops its oldest item and both positions move.
                  wr_en   = 1'b1;
                  wr_addr = head_ff;
                  head_in = head_adv;
                  tail_in = tail_adv;
               end
            end
            CMD_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   assign p1_valid_in  = accept | (p1_valid_ff & ~p1_adv);
   assign rsp_valid_in = p1_adv | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_capacity_in_use;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_status_ff <= status_in;
         p1_hit_ff    <= hit_in;
      end
      if (p1_adv) begin
         rsp_status_ff     <= p1_status_ff;
         rsp_read_value_ff <= p1_hit_ff ? rd_data : '0;
      end
   end

   rfo_ram #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .ADDR_W      (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_write_value),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;

endmodule

// ===== sv/rfo_checker.sv =====
// ----------------------------------------------------------------------------
// rfo_checker
// Port-level checks on the ring FIFO's result channel.
// ----------------------------------------------------------------------------
module rfo_checker
   import rfo_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [VALUE_WIDTH-1:0] rsp_read_value,
   input logic [STATUS_W-1:0]    rsp_status
);

   // Nothing is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A result with a failing status carries a zero read value.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_read_value == '0))
      else $error("failed item carries a read value");

   // Status is one of the defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_EMPTY ||
                     rsp_status == STAT_FULL))
      else $error("undefined status code");

   // A result cannot appear without an earlier accepted item.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !$past(req_valid && !req_stall)) |=> !rsp_valid)
      else $error("result without a preceding item");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_read_value) && $stable(rsp_status)))
      else $error("stalled result changed");

endmodule

bind ring_fifo_with_overwrite_unit rfo_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_rfo_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status)
);
